// File: hdl/fcpu_pkg.sv
// ============================================================================
// fcpu_pkg
// Shared types and constants for the flow constraint projection update.
// ============================================================================
package fcpu_pkg;

    localparam int DATA_WIDTH_DEF = 16;
    localparam int CFG_W          = 17;
    localparam int CFG_IDX_W      = 2;
    localparam int Q16_SHIFT      = 16;

    localparam logic [CFG_W-1:0]     Q16_ONE          = 17'h10000;
    localparam logic [CFG_IDX_W-1:0] REG_LEARN_RATE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLEND_WEIGHT = 2'd1;

    // Control bits that travel down the divider with each word.
    typedef struct packed {
        logic valid;
        logic neg;
        logic zero;
    } t_div_ctl;

endpackage

// File: hdl/fcpu_if.sv
// ============================================================================
// fcpu_if
// Stream and configuration channels of the projection update.
// ============================================================================
interface fcpu_pix_if #(parameter int W = 16);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] f_x;
    logic signed [W-1:0] f_y;
    logic signed [W-1:0] g_x;
    logic signed [W-1:0] g_y;
    logic signed [W-1:0] v_value;
    modport source (output valid, f_x, f_y, g_x, g_y, v_value, input ready);
    modport sink   (input valid, f_x, f_y, g_x, g_y, v_value, output ready);
endinterface

interface fcpu_res_if #(parameter int W = 16);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] new_f_x;
    logic signed [W-1:0] new_f_y;
    logic                saturated;
    modport source (output valid, new_f_x, new_f_y, saturated, input ready);
    modport sink   (input valid, new_f_x, new_f_y, saturated, output ready);
endinterface

interface fcpu_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [16:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/fcpu_front.sv
// ============================================================================
// fcpu_front
// Two stages: products, then numerator and divisor set up for the divider.
// ============================================================================
module fcpu_front #(
    parameter int W  = 16,
    parameter int NW = 47,
    parameter int DW = 33
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic signed [W-1:0]   i_f_x,
    input  logic signed [W-1:0]   i_f_y,
    input  logic signed [W-1:0]   i_g_x,
    input  logic signed [W-1:0]   i_g_y,
    input  logic signed [W-1:0]   i_v,
    output fcpu_pkg::t_div_ctl    o_ctl,
    output logic [NW-1:0]         o_num,
    output logic [DW-1:0]         o_den,
    output logic [4*W-1:0]        o_side
);
    import fcpu_pkg::*;

    localparam int FB   = W - 4;
    localparam int PW   = 2 * W;
    localparam int NUMW = 2 * W + 2;
    localparam int AW   = NUMW - 1 + FB;

    logic                r_v1;
    logic signed [PW-1:0] r_fxgx, r_fygy;
    logic [PW-1:0]        r_gxgx, r_gygy;
    logic signed [W-1:0]  r_v;
    logic [4*W-1:0]       r_side1;

    t_div_ctl             r_ctl;
    logic [NW-1:0]        r_num;
    logic [DW-1:0]        r_den;
    logic [4*W-1:0]       r_side2;

    logic signed [NUMW-1:0] num;
    logic [NUMW-1:0]        mag;
    logic [PW-1:0]          nrm;
    logic [AW-1:0]          a;
    logic signed [PW-1:0]   sq_x, sq_y;

    assign sq_x = i_g_x * i_g_x;
    assign sq_y = i_g_y * i_g_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
        end
        if (i_en) begin
            r_fxgx  <= i_f_x * i_g_x;
            r_fygy  <= i_f_y * i_g_y;
            r_gxgx  <= sq_x;
            r_gygy  <= sq_y;
            r_v     <= i_v;
            r_side1 <= {i_f_x, i_f_y, i_g_x, i_g_y};
        end
    end

    always_comb begin
        num = (NUMW'(r_v) <<< FB) + NUMW'(r_fxgx) + NUMW'(r_fygy);
        mag = num[NUMW-1] ? (~num + 1'b1) : num;
        nrm = r_gxgx + r_gygy;
        a   = {mag[NUMW-2:0], {FB{1'b0}}};
    end

    // Rounded division is floor((2a + d) / 2d).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else if (i_en) begin
            r_ctl.valid <= r_v1;
        end
        if (i_en) begin
            r_ctl.neg  <= num[NUMW-1];
            r_ctl.zero <= (nrm == '0);
            r_num      <= NW'({a, 1'b0}) + NW'(nrm);
            r_den      <= {nrm, 1'b0};
            r_side2    <= r_side1;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_num  = r_num;
    assign o_den  = r_den;
    assign o_side = r_side2;

endmodule

// File: hdl/fcpu_div_stage.sv
// ============================================================================
// fcpu_div_stage
// One restoring-division step: produces one quotient bit per stage.
// ============================================================================
module fcpu_div_stage #(
    parameter int NW = 47,
    parameter int DW = 33,
    parameter int SW = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  fcpu_pkg::t_div_ctl i_ctl,
    input  logic [DW:0]        i_rem,
    input  logic [NW-1:0]      i_num,
    input  logic [DW-1:0]      i_den,
    input  logic [SW-1:0]      i_side,
    output fcpu_pkg::t_div_ctl o_ctl,
    output logic [DW:0]        o_rem,
    output logic [NW-1:0]      o_num,
    output logic [DW-1:0]      o_den,
    output logic [SW-1:0]      o_side
);
    import fcpu_pkg::*;

    t_div_ctl      r_ctl;
    logic [DW:0]   r_rem;
    logic [NW-1:0] r_num;
    logic [DW-1:0] r_den;
    logic [SW-1:0] r_side;

    logic [DW:0] x;
    logic        ge;

    // The numerator shifts out at the top while quotient bits shift in below.
    always_comb begin
        x  = {i_rem[DW-1:0], i_num[NW-1]};
        ge = (x >= {1'b0, i_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else if (i_en) begin
            r_ctl.valid <= i_ctl.valid;
        end
        if (i_en) begin
            r_ctl.neg  <= i_ctl.neg;
            r_ctl.zero <= i_ctl.zero;
            r_rem      <= ge ? (x - {1'b0, i_den}) : x;
            r_num      <= {i_num[NW-2:0], ge};
            r_den      <= i_den;
            r_side     <= i_side;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_rem  = r_rem;
    assign o_num  = r_num;
    assign o_den  = r_den;
    assign o_side = r_side;

endmodule

// File: hdl/fcpu_back.sv
// ============================================================================
// fcpu_back
// Projection, blend, rounding and saturation; ends in the output register.
// ============================================================================
module fcpu_back #(
    parameter int W  = 16,
    parameter int NW = 47
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  fcpu_pkg::t_div_ctl  i_ctl,
    input  logic [NW-1:0]       i_quo,
    input  logic [4*W-1:0]      i_side,
    input  logic [16:0]         i_lw,
    input  logic [16:0]         i_keep,
    output logic                o_valid,
    output logic signed [W-1:0] o_new_f_x,
    output logic signed [W-1:0] o_new_f_y,
    output logic                o_saturated
);
    import fcpu_pkg::*;

    localparam int FB    = W - 4;
    localparam int SPLIT = (NW + 1) / 2;
    localparam int HW    = NW - SPLIT;
    localparam int PLW   = W + SPLIT + 1;
    localparam int PHW   = W + HW + 1;
    localparam int GW    = W + NW + 2;
    localparam int UW    = 2 * W + 2;
    localparam int MW    = UW + 18;
    localparam int KW    = W + 18;
    localparam int ACW   = MW + 1;

    // Stage one: partial products of G and the quotient magnitude.
    logic                  r_v1, r_neg1;
    logic signed [PLW-1:0] r_pxl, r_pyl;
    logic signed [PHW-1:0] r_pxh, r_pyh;
    logic signed [W-1:0]   r_fx1, r_fy1;
    logic [NW-1:0]         quo;
    logic signed [W-1:0]   s_fx, s_fy, s_gx, s_gy;

    assign quo = i_ctl.zero ? '0 : i_quo;
    assign {s_fx, s_fy, s_gx, s_gy} = i_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_ctl.valid;
        end
        if (i_en) begin
            r_neg1 <= i_ctl.neg;
            r_pxl  <= PLW'(s_gx) * $signed({1'b0, quo[SPLIT-1:0]});
            r_pyl  <= PLW'(s_gy) * $signed({1'b0, quo[SPLIT-1:0]});
            r_pxh  <= PHW'(s_gx) * $signed({1'b0, quo[NW-1:SPLIT]});
            r_pyh  <= PHW'(s_gy) * $signed({1'b0, quo[NW-1:SPLIT]});
            r_fx1  <= s_fx;
            r_fy1  <= s_fy;
        end
    end

    // Stage two: u = round((F*2^FB - G*q) / 2^FB), half away from zero.
    logic signed [GW-1:0]  gqx, gqy, tx, ty;
    logic [GW-1:0]         mx_t, my_t;
    logic [GW-1:0]         rx, ry;
    logic signed [UW-1:0]  ux, uy;
    logic                  r_v2;
    logic signed [UW-1:0]  r_ux, r_uy;
    logic signed [W-1:0]   r_fx2, r_fy2;

    always_comb begin
        gqx  = (GW'(r_pxh) <<< SPLIT) + GW'(r_pxl);
        gqy  = (GW'(r_pyh) <<< SPLIT) + GW'(r_pyl);
        if (r_neg1) begin
            gqx = -gqx;
            gqy = -gqy;
        end
        tx   = (GW'(r_fx1) <<< FB) - gqx;
        ty   = (GW'(r_fy1) <<< FB) - gqy;
        mx_t = tx[GW-1] ? (~tx + 1'b1) : tx;
        my_t = ty[GW-1] ? (~ty + 1'b1) : ty;
        rx   = (mx_t + (GW'(1) << (FB - 1))) >> FB;
        ry   = (my_t + (GW'(1) << (FB - 1))) >> FB;
        ux   = tx[GW-1] ? -$signed(rx[UW-1:0]) : $signed(rx[UW-1:0]);
        uy   = ty[GW-1] ? -$signed(ry[UW-1:0]) : $signed(ry[UW-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v2 <= r_v1;
        end
        if (i_en) begin
            r_ux  <= ux;
            r_uy  <= uy;
            r_fx2 <= r_fx1;
            r_fy2 <= r_fy1;
        end
    end

    // Stage three: lw*u and (1-w)*F.
    logic                 r_v3;
    logic signed [MW-1:0] r_mx, r_my;
    logic signed [KW-1:0] r_kx, r_ky;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v3 <= r_v2;
        end
        if (i_en) begin
            r_mx <= MW'($signed({1'b0, i_lw})) * MW'(r_ux);
            r_my <= MW'($signed({1'b0, i_lw})) * MW'(r_uy);
            r_kx <= KW'($signed({1'b0, i_keep})) * KW'(r_fx2);
            r_ky <= KW'($signed({1'b0, i_keep})) * KW'(r_fy2);
        end
    end

    // Stage four: sum, round to Q.FB and saturate into the output register.
    logic signed [ACW-1:0] acx, acy, nx, ny;
    logic [ACW-1:0]        ax, ay, qx, qy;
    logic signed [W-1:0]   sx, sy;
    logic                  clip_x, clip_y;
    logic signed [ACW-1:0] hi_lim, lo_lim;

    always_comb begin
        hi_lim = ACW'({1'b0, {(W-1){1'b1}}});
        lo_lim = -hi_lim - 1'b1;
        acx    = ACW'(r_mx) + ACW'(r_kx);
        acy    = ACW'(r_my) + ACW'(r_ky);
        ax     = acx[ACW-1] ? (~acx + 1'b1) : acx;
        ay     = acy[ACW-1] ? (~acy + 1'b1) : acy;
        qx     = (ax + (ACW'(1) << (Q16_SHIFT - 1))) >> Q16_SHIFT;
        qy     = (ay + (ACW'(1) << (Q16_SHIFT - 1))) >> Q16_SHIFT;
        nx     = acx[ACW-1] ? -$signed(qx) : $signed(qx);
        ny     = acy[ACW-1] ? -$signed(qy) : $signed(qy);
        clip_x = (nx > hi_lim) || (nx < lo_lim);
        clip_y = (ny > hi_lim) || (ny < lo_lim);
        sx     = (nx > hi_lim) ? hi_lim[W-1:0] : ((nx < lo_lim) ? lo_lim[W-1:0] : nx[W-1:0]);
        sy     = (ny > hi_lim) ? hi_lim[W-1:0] : ((ny < lo_lim) ? lo_lim[W-1:0] : ny[W-1:0]);
    end

    logic                r_v4, r_sat;
    logic signed [W-1:0] r_ox, r_oy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (i_en) begin
            r_v4 <= r_v3;
        end
        if (i_en) begin
            r_ox  <= sx;
            r_oy  <= sy;
            r_sat <= clip_x | clip_y;
        end
    end

    assign o_valid     = r_v4;
    assign o_new_f_x   = r_ox;
    assign o_new_f_y   = r_oy;
    assign o_saturated = r_sat;

endmodule

// File: hdl/flow_constraint_projection_update.sv
// ============================================================================
// flow_constraint_projection_update
// Per-pixel projection of F against the constraint (V, G) and blended update.
// ============================================================================
// Usage:
//   i_pix carries one pixel word (f_x, f_y, g_x, g_y, v_value, signed Q4.12).
//   o_res returns one word per pixel (new_f_x, new_f_y, saturated) in order.
//   i_cfg writes learn_rate (index 0) and blend_weight (index 1), Q1.16;
//   values above 1.0 act as 1.0. Write them only while no pixel is in flight.
// Throughput: one pixel per cycle while o_res.ready is high.
// Pipeline: 3*DATA_WIDTH + 5 register stages (53 at DATA_WIDTH = 16) from
//   the accepting edge to o_res: two set-up stages, one restoring-divider
//   stage per quotient bit (3*DATA_WIDTH - 1 of them), and four product,
//   round and saturate stages ending in the output register.
// Stall: when the output word is held, the whole pipeline freezes and
//   i_pix.ready drops; nothing is lost or repeated.
// Reset: synchronous, active low; clears all valid bits and loads
//   learn_rate = 655 and blend_weight = 6554.
// ============================================================================
module flow_constraint_projection_update #(
    parameter int DATA_WIDTH = fcpu_pkg::DATA_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fcpu_pix_if.sink   i_pix,
    fcpu_res_if.source o_res,
    fcpu_cfg_if.sink   i_cfg
);
    import fcpu_pkg::*;

    localparam int W    = DATA_WIDTH;
    localparam int FB   = W - 4;
    localparam int AW   = 2 * W + 1 + FB;
    localparam int NW   = AW + 2;
    localparam int DW   = 2 * W + 1;
    localparam int SW   = 4 * W;

    logic en;
    assign en = !o_res.valid || o_res.ready;
    assign i_pix.ready = en;
    assign i_cfg.ready = 1'b1;

    // Configuration registers and the derived blend factors.
    logic [CFG_W-1:0] r_lr, r_w, r_lw, r_keep;
    logic [CFG_W-1:0] lr_c, w_c;
    logic [2*CFG_W-1:0] lrw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lr <= CFG_W'(655);
            r_w  <= CFG_W'(6554);
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_LEARN_RATE:   r_lr <= i_cfg.data;
                REG_BLEND_WEIGHT: r_w  <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_comb begin
        lr_c = (r_lr > Q16_ONE) ? Q16_ONE : r_lr;
        w_c  = (r_w > Q16_ONE) ? Q16_ONE : r_w;
        lrw  = lr_c * w_c;
    end

    always_ff @(posedge i_clk) begin
        r_lw   <= CFG_W'((lrw + (2*CFG_W)'(1 << (Q16_SHIFT - 1))) >> Q16_SHIFT);
        r_keep <= Q16_ONE - w_c;
    end

    // Divider chain.
    t_div_ctl      ctl  [0:NW];
    logic [DW:0]   rem  [0:NW];
    logic [NW-1:0] num  [0:NW];
    logic [DW-1:0] den  [0:NW];
    logic [SW-1:0] side [0:NW];

    fcpu_front #(.W(W), .NW(NW), .DW(DW)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_pix.valid),
        .i_f_x   (i_pix.f_x),
        .i_f_y   (i_pix.f_y),
        .i_g_x   (i_pix.g_x),
        .i_g_y   (i_pix.g_y),
        .i_v     (i_pix.v_value),
        .o_ctl   (ctl[0]),
        .o_num   (num[0]),
        .o_den   (den[0]),
        .o_side  (side[0])
    );
    assign rem[0] = '0;

    for (genvar k = 0; k < NW; k++) begin : g_div
        fcpu_div_stage #(.NW(NW), .DW(DW), .SW(SW)) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_ctl   (ctl[k]),
            .i_rem   (rem[k]),
            .i_num   (num[k]),
            .i_den   (den[k]),
            .i_side  (side[k]),
            .o_ctl   (ctl[k+1]),
            .o_rem   (rem[k+1]),
            .o_num   (num[k+1]),
            .o_den   (den[k+1]),
            .o_side  (side[k+1])
        );
    end

    fcpu_back #(.W(W), .NW(NW)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_ctl       (ctl[NW]),
        .i_quo       (num[NW]),
        .i_side      (side[NW]),
        .i_lw        (r_lw),
        .i_keep      (r_keep),
        .o_valid     (o_res.valid),
        .o_new_f_x   (o_res.new_f_x),
        .o_new_f_y   (o_res.new_f_y),
        .o_saturated (o_res.saturated)
    );

endmodule

// File: test/flow_constraint_projection_update_test.sv
`timescale 1ns / 1ps
// ============================================================================
// flow_constraint_projection_update_test
// Streams pixel words through the projection update under random sender gaps
// and receiver stalls. Results are compared with a software predictor or a
// typed-in value. Coefficient registers change between phases while idle.
// ============================================================================
module flow_constraint_projection_update_test;
    import fcpu_pkg::*;

    localparam int W       = 16;
    localparam int LATENCY = 3 * W + 5;
    localparam int N_RAND  = 780;

    typedef struct packed {
        logic signed [W-1:0] f_x;
        logic signed [W-1:0] f_y;
        logic signed [W-1:0] g_x;
        logic signed [W-1:0] g_y;
        logic signed [W-1:0] v_value;
    } t_pixel;

    typedef struct packed {
        logic signed [W-1:0] new_f_x;
        logic signed [W-1:0] new_f_y;
        logic                saturated;
    } t_update;

    // One directed row: a pixel and, where obvious, the typed-in result.
    typedef struct packed {
        t_pixel  pix;
        logic    fixed;
        t_update res;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    fcpu_pix_if #(.W(W)) pix_ch ();
    fcpu_res_if #(.W(W)) res_ch ();
    fcpu_cfg_if          cfg_ch ();

    flow_constraint_projection_update #(.DATA_WIDTH(W)) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_pix  (pix_ch.sink),
        .o_res  (res_ch.source),
        .i_cfg  (cfg_ch.sink)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    logic [CFG_W-1:0] learn_rate;
    logic [CFG_W-1:0] blend_weight;
    t_update          pending_updates[$];
    int               fail_count = 0;
    bit               stall_en = 1'b1;
    int               stall_mode = 0;

    function automatic longint round_div(longint n, longint d);
        longint a;
        longint r;
        a = (n < 0) ? -n : n;
        r = (2 * a + d) / (2 * d);
        return (n < 0) ? -r : r;
    endfunction

    function automatic logic signed [W-1:0] clip_q(longint x, ref logic sat_flag);
        longint hi;
        hi = (longint'(1) <<< (W - 1)) - 1;
        if (x > hi) begin
            sat_flag = 1'b1;
            return hi[W-1:0];
        end
        if (x < -hi - 1) begin
            sat_flag = 1'b1;
            return W'(-hi - 1);
        end
        return x[W-1:0];
    endfunction

    function automatic t_update project_update(t_pixel p);
        longint  one_fb;
        longint  fx, fy, gx, gy, v, lr, w, dot_fg, norm_g, num, q, ux, uy, lw, keep;
        logic    sat_flag;
        t_update r;
        one_fb = longint'(1) <<< (W - 4);
        fx = p.f_x; fy = p.f_y; gx = p.g_x; gy = p.g_y; v = p.v_value;
        lr = (learn_rate > Q16_ONE) ? 65536 : longint'(learn_rate);
        w = (blend_weight > Q16_ONE) ? 65536 : longint'(blend_weight);
        dot_fg = fx * gx + fy * gy;
        norm_g = gx * gx + gy * gy;
        num = v * one_fb + dot_fg;
        q = (norm_g == 0) ? 0 : round_div(num * one_fb, norm_g);
        ux = round_div(fx * one_fb - gx * q, one_fb);
        uy = round_div(fy * one_fb - gy * q, one_fb);
        lw = round_div(lr * w, 65536);
        keep = 65536 - w;
        sat_flag = 1'b0;
        r.new_f_x = clip_q(round_div(keep * fx + lw * ux, 65536), sat_flag);
        r.new_f_y = clip_q(round_div(keep * fy + lw * uy, 65536), sat_flag);
        r.saturated = sat_flag;
        return r;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (idx == REG_LEARN_RATE) learn_rate = value;
        else blend_weight = value;
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (pending_updates.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    // Holds valid high until the word is taken, then leaves it high; the
    // caller lowers it only when a gap follows.
    task automatic send_pixel(t_pixel p, bit fixed, t_update want);
        pix_ch.valid   <= 1'b1;
        pix_ch.f_x     <= p.f_x;
        pix_ch.f_y     <= p.f_y;
        pix_ch.g_x     <= p.g_x;
        pix_ch.g_y     <= p.g_y;
        pix_ch.v_value <= p.v_value;
        do @(posedge i_clk); while (!pix_ch.ready);
        pending_updates.push_back(fixed ? want : project_update(p));
    endtask

    task automatic idle_gap(int n);
        pix_ch.valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    function automatic t_pixel random_pixel();
        t_pixel p;
        int     mode;
        mode = $urandom_range(0, 9);
        p = t_pixel'({$urandom, $urandom, 16'($urandom)});
        // Mostly well-conditioned pixels with modest magnitudes; the rest
        // use full-range, zero or very small partner vectors.
        if (mode < 6) begin
            p.f_x = W'(int'($urandom_range(0, 16383)) - 8192);
            p.f_y = W'(int'($urandom_range(0, 16383)) - 8192);
            p.v_value = W'(int'($urandom_range(0, 16383)) - 8192);
            p.g_x = W'(int'($urandom_range(0, 16383)) - 8192);
            p.g_y = W'(int'($urandom_range(0, 16383)) - 8192);
        end else if (mode == 6) begin
            p.g_x = '0;
            p.g_y = '0;
        end else if (mode == 7) begin
            p.g_x = W'(int'($urandom_range(0, 6)) - 3);
            p.g_y = W'(int'($urandom_range(0, 6)) - 3);
        end
        return p;
    endfunction

    // Receiver stall pattern: free-running, light random stalls, or heavy random stalls.
    always @(posedge i_clk) begin
        if (!stall_en) begin
            res_ch.ready <= 1'b1;
        end else begin
            if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
            case (stall_mode)
                0: res_ch.ready <= 1'b1;
                1: res_ch.ready <= ($urandom_range(0, 3) != 0);
                default: res_ch.ready <= ($urandom_range(0, 1) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_update want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_updates.size() == 0) begin
                $error("unexpected result word");
                fail_count++;
            end else begin
                want = pending_updates.pop_front();
                if (res_ch.new_f_x !== want.new_f_x) begin
                    $error("new_f_x: expected %0d, got %0d", want.new_f_x, res_ch.new_f_x);
                    fail_count++;
                end
                if (res_ch.new_f_y !== want.new_f_y) begin
                    $error("new_f_y: expected %0d, got %0d", want.new_f_y, res_ch.new_f_y);
                    fail_count++;
                end
                if (res_ch.saturated !== want.saturated) begin
                    $error("saturated: expected %0d, got %0d", want.saturated,
                           res_ch.saturated);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        #5000000;
        $display("TEST FAILED");
        $finish;
    end

    localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W-1:0] ONE  = W'(1 << (W - 4));

    t_row directed[] = '{
        // Zero vectors give zero.
        '{'{0, 0, 0, 0, 0}, 1'b1, '{0, 0, 1'b0}},
        // Zero partner vector: the projection leaves F alone.
        '{'{ONE, -ONE, 0, 0, MAXV}, 1'b0, '0},
        '{'{MAXV, MINV, 0, 0, MINV}, 1'b0, '0},
        '{'{MAXV, MAXV, MAXV, MAXV, MAXV}, 1'b0, '0},
        '{'{MINV, MINV, MINV, MINV, MINV}, 1'b0, '0},
        '{'{MAXV, MINV, MINV, MAXV, MAXV}, 1'b0, '0},
        '{'{MINV, MAXV, 1, 0, MAXV}, 1'b0, '0},
        '{'{MAXV, MAXV, 0, 1, MINV}, 1'b0, '0},
        '{'{MINV, MINV, 1, 1, MAXV}, 1'b0, '0},
        '{'{ONE, ONE, ONE, 0, ONE}, 1'b0, '0},
        '{'{-ONE, ONE, 0, -ONE, -ONE}, 1'b0, '0},
        '{'{16'h5555, 16'hAAAA, 16'h3333, 16'hCCCC, 16'h0F0F}, 1'b0, '0},
        '{'{16'hAAAA, 16'h5555, 16'hCCCC, 16'h3333, 16'hF0F0}, 1'b0, '0},
        '{'{-1, -1, -1, -1, -1}, 1'b0, '0}
    };

    // learn_rate / blend_weight pairs per phase, extremes and above one.
    logic [CFG_W-1:0] phase_lr[6] = '{17'd655, 17'd65536, 17'd0, 17'h1FFFF, 17'd32768, 17'd1};
    logic [CFG_W-1:0] phase_w[6]  = '{17'd6554, 17'd65536, 17'd65536, 17'h1FFFF, 17'd0, 17'd40000};

    initial begin
        int burst;
        pix_ch.valid = 1'b0;
        pix_ch.f_x = '0; pix_ch.f_y = '0; pix_ch.g_x = '0; pix_ch.g_y = '0;
        pix_ch.v_value = '0;
        cfg_ch.valid = 1'b0; cfg_ch.index = '0; cfg_ch.data = '0;
        res_ch.ready = 1'b1;
        learn_rate = 17'd655;
        blend_weight = 17'd6554;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int ph = 0; ph < 6; ph++) begin
            if (ph != 0) begin
                drain();
                write_reg(REG_LEARN_RATE, phase_lr[ph]);
                write_reg(REG_BLEND_WEIGHT, phase_w[ph]);
            end
            stall_en = (ph != 2);
            foreach (directed[i]) begin
                if (ph == 0 || !directed[i].fixed)
                    send_pixel(directed[i].pix, directed[i].fixed && ph == 0,
                               directed[i].res);
                if ($urandom_range(0, 2) == 0) idle_gap($urandom_range(1, 3));
            end
            burst = 0;
            for (int n = 0; n < N_RAND / 6; n++) begin
                send_pixel(random_pixel(), 1'b0, '0);
                if (burst == 0) begin
                    burst = $urandom_range(1, 20);
                    if (ph != 2) idle_gap($urandom_range(1, 5));
                end else begin
                    burst--;
                end
                // Hold off once until the pipeline runs empty.
                if (ph == 1 && n == 40) begin
                    pix_ch.valid <= 1'b0;
                    while (pending_updates.size() != 0) @(posedge i_clk);
                end
            end
            pix_ch.valid <= 1'b0;
        end

        drain();
        if (fail_count == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end
endmodule

// File: sim.f
hdl/fcpu_pkg.sv
hdl/fcpu_if.sv
hdl/fcpu_front.sv
hdl/fcpu_div_stage.sv
hdl/fcpu_back.sv
hdl/flow_constraint_projection_update.sv
test/flow_constraint_projection_update_test.sv
